FILE: hw/rtl/sdpf_pkg.sv
// ----------------------------------------------------------------------------
// sdpf_pkg: shared types and constants of the spring-damper force pipeline
// Holds the field widths, register indexes and the payload bundles that move
// through the square-root and divider stages.
// ----------------------------------------------------------------------------
package sdpf_pkg;

    localparam int FIELD_W  = 32;   // Q16.16 input and output words
    localparam int CFG_W    = 31;   // configuration register width
    localparam int DIFF_W   = 33;   // exact difference of two fields
    localparam int SQ_W     = 68;   // sum of squares and trial values
    localparam int LEN_W    = 34;   // integer square root of the sum
    localparam int NUM_W    = 50;   // divider numerator and remainder
    localparam int QUO_W    = 17;   // unit-vector magnitude, at most 1.0
    localparam int SQ_N     = 34;   // one square-root bit per stage
    localparam int DV_N     = 17;   // one quotient bit per stage
    localparam int IN_W     = 12 * FIELD_W;
    localparam int OUT_W    = 104;  // 97 payload bits padded to bytes

    // Largest coefficient magnitude kept, 3 * 2^46.
    localparam logic [47:0] COEF_MAX = 48'hC000_0000_0000;

    typedef enum logic [1:0] {
        CFG_STIFFNESS   = 2'd0,
        CFG_DAMPING     = 2'd1,
        CFG_REST_LEN    = 2'd2
    } cfg_index_t;

    // Payload that rides along the square-root stages.
    typedef struct packed {
        logic [2:0][DIFF_W-1:0] dp;
        logic [2:0][DIFF_W-1:0] dv;
    } sq_carry_t;

    // Payload that rides along the divider stages.
    typedef struct packed {
        logic [LEN_W-1:0]       len;
        logic [2:0][DIFF_W-1:0] dv;
        logic [2:0]             sgn;
    } dv_carry_t;

endpackage

FILE: hw/rtl/spring_damper_pair_force_top.sv
// Datapath: a 34-stage square root and a 17-stage divider, each of which
// resolves one bit per stage.
// Throughput: one beat per cycle; the pipeline advances as a whole and holds
// while the output beat waits.
// Reset: rst_n clears all valid bits and the three coefficient registers.
// ----------------------------------------------------------------------------
// spring_damper_pair_force_top: linear spring-damper force between two nodes
// Computes the force on node A from the positions and velocities of nodes A
// and B in signed Q16.16, with a saturated result and a clip flag.
// ----------------------------------------------------------------------------
module spring_damper_pair_force_top
    import sdpf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Coefficient write port.
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    // Input stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
    // vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z (32 bits each)
    input  logic [IN_W-1:0]     s_tdata,
    // Output stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    // force_x [31:0], force_y [63:32], force_z [95:64], saturated [96],
    // zero padding [103:97]
    output logic [OUT_W-1:0]    m_tdata
);

    // Stages: difference, square, sum, square root, numerator setup, divider,
    // rate products, rate sum, coefficient products, coefficient sum and
    // clamp, force products, and the output register.
    localparam int NSTG = 3 + SQ_N + 1 + DV_N + 6;

    logic [CFG_W-1:0] stiffness_reg;
    logic [CFG_W-1:0] damping_reg;
    logic [CFG_W-1:0] rest_len_reg;

    logic [NSTG-1:0]  vld_reg;
    logic             ce;

    // The whole pipeline moves when the output register is empty or drained.
    assign ce       = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg <= '0;
            damping_reg   <= '0;
            rest_len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STIFFNESS:   stiffness_reg <= cfg_data;
                CFG_DAMPING:     damping_reg   <= cfg_data;
                CFG_REST_LEN:    rest_len_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
    end

    // ------------------------------------------------------------------
    // Stage 1: exact relative position and velocity, A minus B.
    // ------------------------------------------------------------------
    logic [2:0][DIFF_W-1:0] s1_dp_reg;
    logic [2:0][DIFF_W-1:0] s1_dv_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_dp_reg[i] <= DIFF_W'($signed(s_tdata[i*FIELD_W +: FIELD_W]))
                              - DIFF_W'($signed(s_tdata[(3+i)*FIELD_W +: FIELD_W]));
                s1_dv_reg[i] <= DIFF_W'($signed(s_tdata[(6+i)*FIELD_W +: FIELD_W]))
                              - DIFF_W'($signed(s_tdata[(9+i)*FIELD_W +: FIELD_W]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares of the position differences.
    // ------------------------------------------------------------------
    logic [2:0][DIFF_W-1:0]   s1_mag;
    logic [2:0][2*DIFF_W-1:0] s2_sq_reg;
    sq_carry_t                s2_cr_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            s1_mag[i] = s1_dp_reg[i][DIFF_W-1] ? DIFF_W'(-s1_dp_reg[i]) : s1_dp_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
                s2_sq_reg[i] <= s1_mag[i] * s1_mag[i];
            s2_cr_reg.dp <= s1_dp_reg;
            s2_cr_reg.dv <= s1_dv_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 and square root: one root bit per stage, restoring method.
    // The remainder holds the radicand minus the square of the partial root.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] sq_root_reg [0:SQ_N];
    logic [SQ_W-1:0]  sq_rem_reg  [0:SQ_N];
    sq_carry_t        sq_cr_reg   [0:SQ_N];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sq_root_reg[0] <= '0;
            sq_rem_reg[0]  <= SQ_W'(s2_sq_reg[0]) + SQ_W'(s2_sq_reg[1])
                            + SQ_W'(s2_sq_reg[2]);
            sq_cr_reg[0]   <= s2_cr_reg;
        end
    end

    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sqrt
        localparam int B = SQ_N - 1 - k;
        logic [SQ_W-1:0] trial;
        logic            take;

        // (r + 2^B)^2 - r^2 with the low B bits of r still zero.
        assign trial = (SQ_W'(sq_root_reg[k]) << (B + 1)) | (SQ_W'(1) << (2 * B));
        assign take  = trial <= sq_rem_reg[k];

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                sq_root_reg[k+1] <= take ? (sq_root_reg[k] | (LEN_W'(1) << B))
                                         : sq_root_reg[k];
                sq_rem_reg[k+1]  <= take ? (sq_rem_reg[k] - trial) : sq_rem_reg[k];
                sq_cr_reg[k+1]   <= sq_cr_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Numerator setup: |dp| * 2^16 + L / 2 for rounding to nearest.
    // ------------------------------------------------------------------
    logic [2:0][NUM_W-1:0] dv_rem_reg [0:DV_N];
    logic [2:0][QUO_W-1:0] dv_quo_reg [0:DV_N];
    dv_carry_t             dv_cr_reg  [0:DV_N];
    logic [2:0][DIFF_W-1:0] sq_mag;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq_mag[i] = sq_cr_reg[SQ_N].dp[i][DIFF_W-1] ? DIFF_W'(-sq_cr_reg[SQ_N].dp[i])
                                                        : sq_cr_reg[SQ_N].dp[i];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= (NUM_W'(sq_mag[i]) << 16)
                                  + NUM_W'(sq_root_reg[SQ_N] >> 1);
                dv_cr_reg[0].sgn[i] <= sq_cr_reg[SQ_N].dp[i][DIFF_W-1];
            end
            dv_quo_reg[0]    <= '0;
            dv_cr_reg[0].len <= sq_root_reg[SQ_N];
            dv_cr_reg[0].dv  <= sq_cr_reg[SQ_N].dv;
        end
    end

    // ------------------------------------------------------------------
    // Divider: three lanes share the divisor L, one quotient bit per stage.
    // The quotient never exceeds 2^16 since each |dp_i| is at most L.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < DV_N; k++)
    begin : g_div
        localparam int B = DV_N - 1 - k;
        logic [NUM_W-1:0] dvsr;
        logic [2:0]       take;

        assign dvsr = NUM_W'(dv_cr_reg[k].len) << B;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
                take[i] = dv_rem_reg[k][i] >= dvsr;
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv_rem_reg[k+1][i] <= take[i] ? (dv_rem_reg[k][i] - dvsr)
                                                  : dv_rem_reg[k][i];
                    dv_quo_reg[k+1][i] <= dv_quo_reg[k][i] | (QUO_W'(take[i]) << B);
                end
                dv_cr_reg[k+1] <= dv_cr_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // M1: products dv_i * u_i and the stretch L minus the rest length.
    // ------------------------------------------------------------------
    logic signed [50:0]    m1_prod_reg [3];
    logic signed [34:0]    m1_stretch_reg;
    logic [2:0][QUO_W-1:0] m1_umag_reg;
    logic [2:0]            m1_usgn_reg;
    logic                  m1_zero_reg;
    logic signed [17:0]    m1_u [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            m1_u[i] = dv_cr_reg[DV_N].sgn[i] ? -$signed({1'b0, dv_quo_reg[DV_N][i]})
                                             :  $signed({1'b0, dv_quo_reg[DV_N][i]});
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
                m1_prod_reg[i] <= 51'($signed(dv_cr_reg[DV_N].dv[i]) * m1_u[i]);
            m1_stretch_reg <= $signed({1'b0, dv_cr_reg[DV_N].len})
                            - $signed({4'b0, rest_len_reg});
            m1_umag_reg    <= dv_quo_reg[DV_N];
            m1_usgn_reg    <= dv_cr_reg[DV_N].sgn;
            m1_zero_reg    <= dv_cr_reg[DV_N].len == '0;
        end
    end

    // ------------------------------------------------------------------
    // M2: rate = floor((sum dv_i*u_i + 2^15) / 2^16).
    // ------------------------------------------------------------------
    logic signed [52:0]    m2_acc;
    logic signed [36:0]    m2_rate_reg;
    logic signed [34:0]    m2_stretch_reg;
    logic [2:0][QUO_W-1:0] m2_umag_reg;
    logic [2:0]            m2_usgn_reg;
    logic                  m2_zero_reg;

    assign m2_acc = 53'(m1_prod_reg[0]) + 53'(m1_prod_reg[1]) + 53'(m1_prod_reg[2])
                  + 53'sd32768;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            m2_rate_reg    <= 37'(m2_acc >>> 16);
            m2_stretch_reg <= m1_stretch_reg;
            m2_umag_reg    <= m1_umag_reg;
            m2_usgn_reg    <= m1_usgn_reg;
            m2_zero_reg    <= m1_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // M3: stiffness * stretch and damping * rate.
    // ------------------------------------------------------------------
    logic signed [66:0]    m3_kp_reg;
    logic signed [68:0]    m3_dr_reg;
    logic [2:0][QUO_W-1:0] m3_umag_reg;
    logic [2:0]            m3_usgn_reg;
    logic                  m3_zero_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            m3_kp_reg   <= 67'($signed({1'b0, stiffness_reg}) * m2_stretch_reg);
            m3_dr_reg   <= 69'($signed({1'b0, damping_reg}) * m2_rate_reg);
            m3_umag_reg <= m2_umag_reg;
            m3_usgn_reg <= m2_usgn_reg;
            m3_zero_reg <= m2_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // M4: coefficient, rounded half up and clamped to +-3*2^46.
    // ------------------------------------------------------------------
    logic signed [69:0]    m4_sum;
    logic signed [53:0]    m4_c;
    logic [47:0]           m4_cmag_reg;
    logic                  m4_cneg_reg;
    logic [2:0][QUO_W-1:0] m4_umag_reg;
    logic [2:0]            m4_usgn_reg;
    logic                  m4_zero_reg;
    logic [47:0]           m4_cmag;

    assign m4_sum = -70'(m3_kp_reg) - 70'(m3_dr_reg) + 70'sd32768;
    assign m4_c   = 54'(m4_sum >>> 16);

    always_comb
    begin
        priority if (m4_c > $signed({6'b0, COEF_MAX}))
            m4_cmag = COEF_MAX;
        else if (m4_c < -$signed({6'b0, COEF_MAX}))
            m4_cmag = COEF_MAX;
        else if (m4_c[53])
            m4_cmag = 48'(-m4_c);
        else
            m4_cmag = 48'(m4_c);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            m4_cmag_reg <= m4_cmag;
            m4_cneg_reg <= m4_c[53];
            m4_umag_reg <= m3_umag_reg;
            m4_usgn_reg <= m3_usgn_reg;
            m4_zero_reg <= m3_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // M5: force magnitudes |c| * |u_i| and their signs.
    // ------------------------------------------------------------------
    logic [2:0][64:0] m5_p_reg;
    logic [2:0]       m5_neg_reg;
    logic             m5_zero_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
                m5_p_reg[i] <= 65'(m4_cmag_reg) * 65'(m4_umag_reg[i]);
            m5_neg_reg  <= {3{m4_cneg_reg}} ^ m4_usgn_reg;
            m5_zero_reg <= m4_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // M6: rounding half up, saturation and the output register.
    // ------------------------------------------------------------------
    logic [2:0][49:0]         m6_m;
    logic [2:0]               m6_clip;
    logic [2:0][FIELD_W-1:0]  m6_f;
    logic [2:0][FIELD_W-1:0]  out_force_reg;
    logic                     out_sat_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (m5_neg_reg[i])
            begin
                m6_m[i]    = 50'((m5_p_reg[i] + 65'd32767) >> 16);
                m6_clip[i] = m6_m[i] > 50'h8000_0000;
                m6_f[i]    = m6_clip[i] ? 32'h8000_0000 : 32'(-m6_m[i]);
            end
            else
            begin
                m6_m[i]    = 50'((m5_p_reg[i] + 65'd32768) >> 16);
                m6_clip[i] = m6_m[i] > 50'h7FFF_FFFF;
                m6_f[i]    = m6_clip[i] ? 32'h7FFF_FFFF : m6_m[i][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // Coincident nodes give a zero direction and hence a zero force.
            out_force_reg <= m5_zero_reg ? '0 : m6_f;
            out_sat_reg   <= !m5_zero_reg && (m6_clip != 3'b000);
        end
    end

    assign m_tdata = {7'b0, out_sat_reg, out_force_reg[2], out_force_reg[1],
                      out_force_reg[0]};

endmodule

FILE: verif/spring_damper_pair_force_top_test.sv
// ----------------------------------------------------------------------------
// spring_damper_pair_force_top_test: self-checking bench for the pair force
// Streams node pairs through the block under several coefficient settings and
// idling patterns, predicts each force beat in fixed point and checks it.
// ----------------------------------------------------------------------------
module spring_damper_pair_force_top_test
    import sdpf_pkg::*;
();

    typedef struct {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic        clip;
    } force_t;

    // Scoreboard: predicts the force of each accepted pair and keeps the
    // predictions in arrival order until the output beats come back.
    class force_scoreboard;
        logic [30:0] k_spring;
        logic [30:0] k_damp;
        logic [30:0] rest_len;
        force_t      pending[$];
        int          n_errors;
        int          n_checked;

        function new();
            k_spring = 0;
            k_damp = 0;
            rest_len = 0;
            n_errors = 0;
            n_checked = 0;
        endfunction

        function logic [33:0] isqrt(logic [67:0] q);
            logic [33:0] r;
            logic [33:0] cand;
            r = 0;
            for (int b = 33; b >= 0; b--)
            begin
                cand = r | (34'd1 << b);
                if ({68'd0, cand} * {68'd0, cand} <= {68'd0, q})
                    r = cand;
            end
            return r;
        endfunction

        function force_t predict(logic [IN_W-1:0] d);
            force_t f;
            logic signed [33:0] dp[3];
            logic signed [33:0] dv[3];
            logic signed [33:0] u[3];
            logic [67:0] q;
            logic [33:0] len;
            logic [63:0] m;
            logic signed [63:0] acc;
            logic signed [63:0] rate;
            logic signed [63:0] stretch;
            logic signed [127:0] sum;
            logic signed [127:0] coef;
            logic signed [127:0] cmax;
            logic signed [127:0] p;
            logic signed [127:0] fi;
            logic [31:0] outv[3];
            q = 0;
            for (int i = 0; i < 3; i++)
            begin
                dp[i] = $signed(d[32*i +: 32]) - $signed(d[32*(i+3) +: 32]);
                dv[i] = $signed(d[32*(i+6) +: 32]) - $signed(d[32*(i+9) +: 32]);
                q += 68'(dp[i] * dp[i]);
            end
            len = isqrt(q);
            f.fx = 0; f.fy = 0; f.fz = 0; f.clip = 0;
            if (len == 0)
                return f;
            acc = 0;
            for (int i = 0; i < 3; i++)
            begin
                // Direction rounds to nearest, ties away from zero.
                m = ((64'(dp[i] < 0 ? -dp[i] : dp[i]) << 16) + len / 2) / len;
                u[i] = dp[i] < 0 ? -34'(m) : 34'(m);
                acc += 64'(dv[i]) * 64'(u[i]);
            end
            rate = (acc + 64'sd32768) >>> 16;
            stretch = $signed({30'd0, len}) - $signed({33'd0, rest_len});
            sum = -($signed({97'd0, k_spring}) * 128'(stretch))
                  - ($signed({97'd0, k_damp}) * 128'(rate)) + 128'sd32768;
            coef = sum >>> 16;
            cmax = 128'sd3 <<< 46;
            if (coef > cmax) coef = cmax;
            if (coef < -cmax) coef = -cmax;
            for (int i = 0; i < 3; i++)
            begin
                p = coef * 128'(u[i]);
                fi = (p + 128'sd32768) >>> 16;
                if (fi > 128'sd2147483647)
                begin
                    fi = 128'sd2147483647; f.clip = 1;
                end
                else if (fi < -128'sd2147483648)
                begin
                    fi = -128'sd2147483648; f.clip = 1;
                end
                outv[i] = fi[31:0];
            end
            f.fx = outv[0]; f.fy = outv[1]; f.fz = outv[2];
            return f;
        endfunction

        function void note_pair(logic [IN_W-1:0] d);
            pending.push_back(predict(d));
        endfunction

        // One line per mismatch, and the tally.
        task report(string what, logic [31:0] got, logic [31:0] want);
            n_errors++;
            $display("mismatch in %s: got %h, expected %h", what, got, want);
        endtask

        task check_beat(logic [OUT_W-1:0] t);
            force_t w;
            if (pending.size() == 0)
            begin
                report("unexpected beat", t[31:0], 32'd0);
                return;
            end
            w = pending.pop_front();
            n_checked++;
            if (t[31:0] !== w.fx) report("force_x", t[31:0], w.fx);
            if (t[63:32] !== w.fy) report("force_y", t[63:32], w.fy);
            if (t[95:64] !== w.fz) report("force_z", t[95:64], w.fz);
            if (t[96] !== w.clip) report("saturated", {31'd0, t[96]}, {31'd0, w.clip});
        endtask

        function void set_reg(cfg_index_t idx, logic [30:0] v);
            case (idx)
                CFG_STIFFNESS:   k_spring = v;
                CFG_DAMPING:     k_damp = v;
                CFG_REST_LEN:    rest_len = v;
                default: ;
            endcase
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;

    force_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int n_sent;
    longint cycle_count;

    localparam longint CYCLE_LIMIT = 400000;
    localparam int LATENCY = 61;

    spring_damper_pair_force_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver: random back-pressure and checking of every output beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [30:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        sb.set_reg(idx, v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Present one beat and hold it until it is taken. The valid stays high
    // afterwards so that the next beat can follow without a gap; callers
    // that wait drop it first.
    task automatic send_pair(logic [IN_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge clk); while (!s_tready);
        sb.note_pair(d);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_word(int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
            2: return 32'($signed($urandom_range(1 << 18)) - (1 << 17));
            default: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rnd_pair();
        logic [IN_W-1:0] d;
        int kind;
        kind = $urandom_range(9);
        kind = kind < 2 ? 0 : (kind < 6 ? 1 : (kind < 9 ? 2 : 3));
        for (int i = 0; i < 12; i++)
            d[32*i +: 32] = rnd_word(kind);
        // Now and then make the nodes coincide, or nearly so.
        if ($urandom_range(15) == 0)
            d[95:0] = d[191:96];
        else if ($urandom_range(15) == 0)
            d[95:0] = d[191:96] + 96'($urandom_range(3));
        return d;
    endfunction

    function automatic logic [IN_W-1:0] pair_of(logic [31:0] a, logic [31:0] b,
                                               logic [31:0] va, logic [31:0] vb);
        return {{3{vb}}, {3{va}}, {3{b}}, {3{a}}};
    endfunction

    initial
    begin
        logic [30:0] kset[4][3];
        sb = new();
        cycle_count = 0;
        n_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_STIFFNESS;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset coefficients, coincident nodes, extremes.
        send_pair('0);
        drain();
        write_reg(CFG_STIFFNESS, 31'h0001_0000);
        write_reg(CFG_DAMPING, 31'h0000_8000);
        write_reg(CFG_REST_LEN, 31'h0001_0000);
        send_pair(pair_of(32'h0003_0000, 32'h0, 32'h0001_0000, 32'h0));
        send_pair(pair_of(32'h0, 32'h0003_0000, 32'h0, 32'h0001_0000));
        send_pair(pair_of(32'h1234_5678, 32'h1234_5678, 32'h7fff_ffff, 32'h8000_0000));
        send_pair(pair_of(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        send_pair(pair_of(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        send_pair(pair_of(32'h0000_0001, 32'h0, 32'h0, 32'h0));
        send_pair(pair_of(32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'h0));
        send_pair({{6{32'hffff_ffff}}, {6{32'h0}}});
        send_pair({{6{32'h0}}, {6{32'hffff_ffff}}});
        drain();
        write_reg(CFG_STIFFNESS, 31'h7fff_ffff);
        write_reg(CFG_DAMPING, 31'h7fff_ffff);
        write_reg(CFG_REST_LEN, 31'h7fff_ffff);
        send_pair(pair_of(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        send_pair(pair_of(32'h0000_0100, 32'h0, 32'h0, 32'h0000_0100));
        send_pair(pair_of(32'h0, 32'h0, 32'h1, 32'h0));
        drain();

        // Random phases, each with its own coefficients and idling.
        kset = '{'{31'h0, 31'h0, 31'h0},
                 '{31'h0004_0000, 31'h0000_4000, 31'h0020_0000},
                 '{31'h7fff_ffff, 31'h0, 31'h0},
                 '{31'h0000_0001, 31'h7fff_ffff, 31'h7fff_ffff}};
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph < 4)
            begin
                write_reg(CFG_STIFFNESS, kset[ph][0]);
                write_reg(CFG_DAMPING, kset[ph][1]);
                write_reg(CFG_REST_LEN, kset[ph][2]);
            end
            else
            begin
                write_reg(CFG_STIFFNESS, 31'($urandom_range(32'h0010_0000)));
                write_reg(CFG_DAMPING, 31'($urandom_range(32'h0010_0000)));
                write_reg(CFG_REST_LEN, 31'($urandom));
            end
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 62; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 62;
                end
                default:
                begin
                    send_idle_pct = 37; recv_stall_pct = 37;
                end
            endcase
            for (int i = 0; i < 216; i++)
            begin
                send_pair(rnd_pair());
                // Hold off once mid-phase until every result is back.
                if (ph == 2 && i == 100)
                begin
                    s_tvalid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge clk);
                end
            end
            drain();
        end

        $display("sent %0d pairs over 8 coefficient settings and 4 idling patterns,",
                 n_sent);
        $display("checked %0d force beats, %0d mismatches", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/sdpf_pkg.sv
hw/rtl/spring_damper_pair_force_top.sv
verif/spring_damper_pair_force_top_test.sv
